// ===== sv/msd_pkg.sv =====
`timescale 1ns / 1ps

package msd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int Q_BITS      = 8;
	localparam int INDEX_W     = 10;
	localparam int TREND_W     = 24;
	localparam int SEASON_W    = 28;
	localparam int RESID_W     = 28;
	localparam int STATUS_W    = 2;
	localparam int WIN_REG_W   = 8;
	localparam int PER_REG_W   = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;

	localparam logic [CFG_IDX_W-1:0] REG_TREND_WINDOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEASON_PERIOD = 1'd1;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_TRUNC = 2'd2;

	typedef struct packed {
		logic                          req_type;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
		logic [INDEX_W-1:0]            index;
	} req_t;

	typedef struct packed {
		logic signed [TREND_W-1:0]  trend_value;
		logic signed [SEASON_W-1:0] season_value;
		logic signed [RESID_W-1:0]  residual_value;
		logic [INDEX_W-1:0]         read_index;
		logic [STATUS_W-1:0]        status;
	} rsp_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_DONE0,
		OP_T0,
		OP_T1,
		OP_T2,
		OP_TDIV,
		OP_TEND,
		OP_AWR,
		OP_BINIT,
		OP_BRD,
		OP_BDIV,
		OP_BWR,
		OP_BZERO,
		OP_CINIT,
		OP_CRD,
		OP_CACC,
		OP_MDIV,
		OP_MEND,
		OP_RLOAD,
		OP_RMOD,
		OP_RMRD,
		OP_RSE,
		OP_EMIT,
		OP_EMITBAD
	} dp_op_t;

	typedef struct packed {
		logic   acc;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic per_zero;
		logic rd_ok;
		logic last_i;
		logic last_ph;
		logic ph_beyond;
	} dp_stat_t;

endpackage

// ===== sv/msd_ram.sv =====
`timescale 1ns / 1ps

module msd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/msd_div.sv =====
`timescale 1ns / 1ps

// Signed-by-unsigned restoring divider, one quotient bit per cycle.
// Quotient truncates toward zero; rem is the remainder of the magnitudes.
module msd_div #(
	parameter int DVD_W = 37,
	parameter int DVS_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dvd,
	input  logic [DVS_W-1:0]        dvs,
	output logic                    done,
	output logic signed [DVD_W-1:0] quot,
	output logic [DVS_W-1:0]        rem
);

	localparam int CW = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dvd[DVD_W-1];
			quo_q <= dvd[DVD_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -signed'(quo_q) : signed'(quo_q);
	assign rem  = rem_q;

endmodule

// ===== sv/msd_datapath.sv =====
`timescale 1ns / 1ps

module msd_datapath #(
	parameter int MAX_LEN    = 1024,
	parameter int MAX_WINDOW = 255,
	parameter int MAX_PERIOD = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [msd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  msd_pkg::req_t                   req,
	input  msd_pkg::dp_cmd_t                cmd,
	output msd_pkg::dp_stat_t               stat,
	output logic                            result_valid,
	output msd_pkg::rsp_t                   result
);

	import msd_pkg::*;

	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam int AWL    = $clog2(MAX_LEN);
	localparam int PH_W   = $clog2(MAX_PERIOD + 1);
	localparam int AWP    = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
	localparam int WIN_W  = $clog2(MAX_WINDOW + 2);
	localparam int PS_W   = SAMPLE_BITS + AWL + 1;
	localparam int TR_W   = SAMPLE_BITS + Q_BITS + 1;
	localparam int DET_W  = TR_W + 1;
	localparam int SUM_W  = DET_W + CNT_W;
	localparam int MEAN_W = DET_W;
	localparam int TOT_W  = MEAN_W + CNT_W;
	localparam int SE_W   = MEAN_W + 1;
	localparam int RES_W  = MEAN_W + 3;
	localparam int SC_W   = SUM_W + CNT_W;
	localparam int DV_A   = (PS_W + Q_BITS > SUM_W) ? PS_W + Q_BITS : SUM_W;
	localparam int DV_B   = (TOT_W > INDEX_W + 1) ? TOT_W : INDEX_W + 1;
	localparam int DVD_W  = (DV_A > DV_B) ? DV_A : DV_B;
	localparam int DS_A   = (WIN_W > CNT_W) ? WIN_W : CNT_W;
	localparam int DVS_W  = (DS_A > PH_W) ? DS_A : PH_W;

	// configuration and series control
	logic [WIN_REG_W-1:0]     twin_q;
	logic [PER_REG_W-1:0]     preg_q;
	logic [CNT_W-1:0]         n_q;
	logic                     trunc_q;
	logic                     ready_q;
	logic signed [PS_W-1:0]   psum_q;
	logic [PH_W-1:0]          per_q;
	logic [CNT_W-1:0]         i_q;
	logic [PH_W-1:0]          ph_q;
	logic                     valid_q;

	// working payload
	logic [INDEX_W-1:0]       idx_q;
	logic                     pa_zero_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [PS_W-1:0]   pa_q;
	logic signed [PS_W-1:0]   pb_q;
	logic signed [TR_W-1:0]   tr_q;
	logic signed [TOT_W-1:0]  total_q;
	logic signed [MEAN_W-1:0] smean_q;
	logic signed [SE_W-1:0]   se_q;
	rsp_t                     rsp_q;

	logic [WIN_W-1:0]         w_clip, w_eff, w_half;
	logic [PH_W-1:0]          per_clip;
	logic [CNT_W-1:0]         nbase;
	logic signed [PS_W-1:0]   pbase, ps_new;
	logic                     full, app_we;
	logic [31:0]              stop_sum, stop_lim;
	logic [AWL-1:0]           start_addr, stop_addr;
	logic                     first;
	logic signed [DET_W-1:0]  y8, det;
	logic signed [SUM_W-1:0]  sc_sum;
	logic [CNT_W-1:0]         sc_cnt;
	logic signed [MEAN_W-1:0] mean_rd;
	logic signed [RES_W-1:0]  resid;
	logic [PH_W-1:0]          ph_next;

	logic [SAMPLE_BITS-1:0]   smp_rdata;
	logic [PS_W-1:0]          pfx_rdata;
	logic                     pfx_re;
	logic [AWL-1:0]           pfx_raddr;
	logic [SC_W-1:0]          sc_rdata;
	logic                     sc_re;
	logic [MEAN_W-1:0]        mean_rdata;
	logic                     mean_re, mean_we;
	logic [AWP-1:0]           mean_raddr;
	logic [MEAN_W-1:0]        mean_wdata;

	logic                     div_start, div_done;
	logic signed [DVD_W-1:0]  div_dvd, div_quot;
	logic [DVS_W-1:0]         div_dvs, div_rem;

	always_comb begin
		if (twin_q == '0) begin
			w_clip = WIN_W'(1);
		end else if (32'(twin_q) > 32'(MAX_WINDOW)) begin
			w_clip = WIN_W'(MAX_WINDOW);
		end else begin
			w_clip = WIN_W'(twin_q);
		end
		w_eff  = w_clip | WIN_W'(1);
		w_half = w_eff >> 1;
		per_clip = (32'(preg_q) > 32'(MAX_PERIOD)) ? PH_W'(MAX_PERIOD) : PH_W'(preg_q);

		nbase  = ready_q ? '0 : n_q;
		pbase  = ready_q ? '0 : psum_q;
		ps_new = pbase + PS_W'(req.sample);
		full   = (32'(nbase) >= 32'(MAX_LEN));
		app_we = cmd.acc && (req.req_type == REQ_APPEND) && !full;

		// clipped window: prefix[start] lives at start-1, prefix[stop] at stop-1
		start_addr = AWL'(32'(i_q) - 32'(w_half) - 32'd1);
		stop_sum   = 32'(i_q) + 32'(w_half);
		stop_lim   = 32'(n_q) - 32'd1;
		stop_addr  = AWL'((stop_sum < stop_lim) ? stop_sum : stop_lim);

		first   = (32'(i_q) < 32'(per_q));
		y8      = DET_W'(y_q) <<< Q_BITS;
		det     = y8 - DET_W'(tr_q);
		sc_sum  = signed'(sc_rdata[SC_W-1:CNT_W]);
		sc_cnt  = sc_rdata[CNT_W-1:0];
		mean_rd = signed'(mean_rdata);
		resid   = RES_W'(y8) - RES_W'(tr_q) - RES_W'(se_q);
		ph_next = (ph_q == per_q - 1'b1) ? '0 : ph_q + 1'b1;

		stat.div_done  = div_done;
		stat.per_zero  = (per_q == '0);
		stat.rd_ok     = ready_q && (32'(idx_q) < 32'(n_q));
		stat.last_i    = (i_q == n_q - 1'b1);
		stat.last_ph   = (ph_q == per_q - 1'b1);
		stat.ph_beyond = (32'(ph_q) >= 32'(n_q));
	end

	// memory port steering
	always_comb begin
		pfx_re     = 1'b0;
		pfx_raddr  = start_addr;
		sc_re      = 1'b0;
		mean_re    = 1'b0;
		mean_raddr = AWP'(ph_q);
		mean_we    = 1'b0;
		mean_wdata = MEAN_W'(div_quot);
		div_start  = 1'b0;
		div_dvd    = DVD_W'(signed'({pb_q - pa_q, {Q_BITS{1'b0}}}));
		div_dvs    = DVS_W'(w_eff);
		case (cmd.op)
			OP_T0: begin
				pfx_re = 1'b1;
				sc_re  = 1'b1;
			end
			OP_T1: begin
				pfx_re    = 1'b1;
				pfx_raddr = stop_addr;
			end
			OP_TDIV: div_start = 1'b1;
			OP_BRD: sc_re = 1'b1;
			OP_BDIV: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(sc_sum);
				div_dvs   = DVS_W'(sc_cnt);
			end
			OP_BWR: mean_we = 1'b1;
			OP_BZERO: begin
				mean_we    = 1'b1;
				mean_wdata = '0;
			end
			OP_CRD: mean_re = 1'b1;
			OP_MDIV: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(total_q);
				div_dvs   = DVS_W'(n_q);
			end
			OP_RMOD: begin
				div_start = 1'b1;
				div_dvd   = signed'(DVD_W'(idx_q));
				div_dvs   = DVS_W'(per_q);
			end
			OP_RMRD: begin
				mean_re    = 1'b1;
				mean_raddr = AWP'(div_rem);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			twin_q  <= WIN_REG_W'(1);
			preg_q  <= '0;
			n_q     <= '0;
			trunc_q <= 1'b0;
			ready_q <= 1'b0;
			psum_q  <= '0;
			per_q   <= '0;
			i_q     <= '0;
			ph_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TREND_WINDOW:  twin_q <= WIN_REG_W'(cfg_wdata);
					REG_SEASON_PERIOD: preg_q <= PER_REG_W'(cfg_wdata);
					default: ;
				endcase
			end
			if (cmd.acc && (req.req_type == REQ_APPEND)) begin
				ready_q <= 1'b0;
				if (full) begin
					n_q     <= nbase;
					psum_q  <= pbase;
					trunc_q <= 1'b1;
				end else begin
					n_q     <= nbase + 1'b1;
					psum_q  <= ps_new;
					trunc_q <= ready_q ? 1'b0 : trunc_q;
				end
			end
			case (cmd.op)
				OP_INIT: begin
					per_q <= per_clip;
					i_q   <= '0;
					ph_q  <= '0;
				end
				OP_DONE0: ready_q <= 1'b1;
				OP_AWR: begin
					i_q  <= i_q + 1'b1;
					ph_q <= ph_next;
				end
				OP_BINIT: ph_q <= '0;
				OP_BWR, OP_BZERO: ph_q <= ph_q + 1'b1;
				OP_CINIT: begin
					i_q  <= '0;
					ph_q <= '0;
				end
				OP_CACC: begin
					i_q  <= i_q + 1'b1;
					ph_q <= ph_next;
				end
				OP_MEND: ready_q <= 1'b1;
				OP_RLOAD: i_q <= CNT_W'(idx_q);
				OP_EMIT, OP_EMITBAD: valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc && (req.req_type == REQ_READ)) begin
			idx_q <= req.index;
		end
		case (cmd.op)
			OP_DONE0: smean_q <= '0;
			OP_T0: pa_zero_q <= (32'(i_q) <= 32'(w_half));
			OP_T1: begin
				y_q  <= signed'(smp_rdata);
				pa_q <= pa_zero_q ? '0 : signed'(pfx_rdata);
			end
			OP_T2: pb_q <= signed'(pfx_rdata);
			OP_TEND: tr_q <= TR_W'(div_quot);
			OP_CINIT: total_q <= '0;
			OP_CACC: total_q <= total_q + TOT_W'(mean_rd);
			OP_MEND: smean_q <= MEAN_W'(div_quot);
			OP_RSE: se_q <= (per_q == '0) ? '0 : SE_W'(mean_rd) - SE_W'(smean_q);
			OP_EMIT: begin
				rsp_q.trend_value    <= TREND_W'(tr_q);
				rsp_q.season_value   <= SEASON_W'(se_q);
				rsp_q.residual_value <= RESID_W'(resid);
				rsp_q.read_index     <= idx_q;
				rsp_q.status         <= trunc_q ? STAT_TRUNC : STAT_OK;
			end
			OP_EMITBAD: begin
				rsp_q.trend_value    <= '0;
				rsp_q.season_value   <= '0;
				rsp_q.residual_value <= '0;
				rsp_q.read_index     <= idx_q;
				rsp_q.status         <= STAT_BAD;
			end
			default: ;
		endcase
	end

	msd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_smp (
		.clk   (clk),
		.we    (app_we),
		.waddr (AWL'(nbase)),
		.wdata (req.sample),
		.re    (cmd.op == OP_T0),
		.raddr (AWL'(i_q)),
		.rdata (smp_rdata)
	);

	// entry k holds the prefix sum over samples 0..k
	msd_ram #(.WIDTH(PS_W), .DEPTH(MAX_LEN)) u_pfx (
		.clk   (clk),
		.we    (app_we),
		.waddr (AWL'(nbase)),
		.wdata (ps_new),
		.re    (pfx_re),
		.raddr (pfx_raddr),
		.rdata (pfx_rdata)
	);

	// per-phase running sum and count; first visit of a phase overwrites
	msd_ram #(.WIDTH(SC_W), .DEPTH(MAX_PERIOD)) u_sc (
		.clk   (clk),
		.we    (cmd.op == OP_AWR),
		.waddr (AWP'(ph_q)),
		.wdata (first ? {SUM_W'(det), CNT_W'(1)} : {sc_sum + SUM_W'(det), sc_cnt + 1'b1}),
		.re    (sc_re),
		.raddr (AWP'(ph_q)),
		.rdata (sc_rdata)
	);

	msd_ram #(.WIDTH(MEAN_W), .DEPTH(MAX_PERIOD)) u_mean (
		.clk   (clk),
		.we    (mean_we),
		.waddr (AWP'(ph_q)),
		.wdata (mean_wdata),
		.re    (mean_re),
		.raddr (mean_raddr),
		.rdata (mean_rdata)
	);

	msd_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	assign result_valid = valid_q;
	assign result       = rsp_q;

endmodule

// ===== sv/msd_ctrl.sv =====
`timescale 1ns / 1ps

module msd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  msd_pkg::req_t      req,
	input  msd_pkg::dp_stat_t  stat,
	output msd_pkg::dp_cmd_t   cmd,
	output logic               busy
);

	import msd_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ENTER,
		S_PCHK,
		S_AT0,
		S_AT1,
		S_AT2,
		S_ADIV,
		S_AWAIT,
		S_AWR,
		S_BINIT,
		S_BRD,
		S_BCHK,
		S_BWAIT,
		S_CINIT,
		S_CRD,
		S_CACC,
		S_MDIV,
		S_MWAIT,
		S_RCHK,
		S_RT0,
		S_RT1,
		S_RT2,
		S_RDIV,
		S_RWAIT,
		S_RMOD,
		S_RMWAIT,
		S_RSE,
		S_REMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		busy    = (state_q != S_IDLE);
		cmd.acc = start && !busy;
		cmd.op  = OP_NONE;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.acc) begin
					if (req.req_type == REQ_READ) begin
						state_d = S_RCHK;
					end else if (req.last) begin
						state_d = S_ENTER;
					end
				end
			end
			S_ENTER: begin
				cmd.op  = OP_INIT;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (stat.per_zero) begin
					cmd.op  = OP_DONE0;
					state_d = S_IDLE;
				end else begin
					state_d = S_AT0;
				end
			end
			S_AT0: begin
				cmd.op  = OP_T0;
				state_d = S_AT1;
			end
			S_AT1: begin
				cmd.op  = OP_T1;
				state_d = S_AT2;
			end
			S_AT2: begin
				cmd.op  = OP_T2;
				state_d = S_ADIV;
			end
			S_ADIV: begin
				cmd.op  = OP_TDIV;
				state_d = S_AWAIT;
			end
			S_AWAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_TEND;
					state_d = S_AWR;
				end
			end
			S_AWR: begin
				cmd.op  = OP_AWR;
				state_d = stat.last_i ? S_BINIT : S_AT0;
			end
			S_BINIT: begin
				cmd.op  = OP_BINIT;
				state_d = S_BRD;
			end
			S_BRD: begin
				cmd.op  = OP_BRD;
				state_d = S_BCHK;
			end
			S_BCHK: begin
				if (stat.ph_beyond) begin
					cmd.op  = OP_BZERO;
					state_d = stat.last_ph ? S_CINIT : S_BRD;
				end else begin
					cmd.op  = OP_BDIV;
					state_d = S_BWAIT;
				end
			end
			S_BWAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_BWR;
					state_d = stat.last_ph ? S_CINIT : S_BRD;
				end
			end
			S_CINIT: begin
				cmd.op  = OP_CINIT;
				state_d = S_CRD;
			end
			S_CRD: begin
				cmd.op  = OP_CRD;
				state_d = S_CACC;
			end
			S_CACC: begin
				cmd.op  = OP_CACC;
				state_d = stat.last_i ? S_MDIV : S_CRD;
			end
			S_MDIV: begin
				cmd.op  = OP_MDIV;
				state_d = S_MWAIT;
			end
			S_MWAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_MEND;
					state_d = S_IDLE;
				end
			end
			S_RCHK: begin
				if (stat.rd_ok) begin
					cmd.op  = OP_RLOAD;
					state_d = S_RT0;
				end else begin
					cmd.op  = OP_EMITBAD;
					state_d = S_IDLE;
				end
			end
			S_RT0: begin
				cmd.op  = OP_T0;
				state_d = S_RT1;
			end
			S_RT1: begin
				cmd.op  = OP_T1;
				state_d = S_RT2;
			end
			S_RT2: begin
				cmd.op  = OP_T2;
				state_d = S_RDIV;
			end
			S_RDIV: begin
				cmd.op  = OP_TDIV;
				state_d = S_RWAIT;
			end
			S_RWAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_TEND;
					state_d = stat.per_zero ? S_RSE : S_RMOD;
				end
			end
			S_RMOD: begin
				cmd.op  = OP_RMOD;
				state_d = S_RMWAIT;
			end
			S_RMWAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_RMRD;
					state_d = S_RSE;
				end
			end
			S_RSE: begin
				cmd.op  = OP_RSE;
				state_d = S_REMIT;
			end
			S_REMIT: begin
				cmd.op  = OP_EMIT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/moving_average_seasonal_decomposer.sv =====
`timescale 1ns / 1ps

// Additive seasonal decomposition of a sample series. An item is taken at a
// clock edge with start high and busy low. An append item (req_type 0) leaves
// busy low, so appends can stream every cycle; samples past MAX_LEN are
// dropped and later reads report truncated status. The append marked last
// starts the computation. With period 0 it stops after the init and
// period-check states. Otherwise it computes the trend and the phase sums
// sample by sample, then a mean per phase, then the mean of the season over
// the series, all on the shared bit-serial divider (dividend width 37 bits at
// the default parameters). A read item (req_type 1) recomputes the trend at
// its index and, with a season, divides the index by the period to find its
// phase; a read that finds no results or an index past the series returns
// from the check state. Each read gives exactly one result beat, in the cycle
// after busy falls, held on result for a single cycle with result_valid high:
// the receiver cannot stall it, so it must take the beat then. Configuration
// writes through cfg_we/cfg_index/cfg_wdata land at once and must be made
// while busy is low; the window is used at compute and read time, the period
// is captured at compute start.
// No memory clearing is needed after reset.
module moving_average_seasonal_decomposer #(
	parameter int MAX_LEN    = 1024,
	parameter int MAX_WINDOW = 255,
	parameter int MAX_PERIOD = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [msd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            start,
	input  msd_pkg::req_t                   req,
	output logic                            busy,
	output logic                            result_valid,
	output msd_pkg::rsp_t                   result
);

	import msd_pkg::*;

	// controller <-> datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	msd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// sample/prefix/phase memories, divider and result beat register
	msd_datapath #(
		.MAX_LEN    (MAX_LEN),
		.MAX_WINDOW (MAX_WINDOW),
		.MAX_PERIOD (MAX_PERIOD)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.req          (req),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Bench for the seasonal decomposer.
// Series are streamed in as append beats. The closing append kicks off the
// computation, and read beats then fetch trend, season and residual at an
// index. A shadow model updates on every accepted beat and queues the
// response it expects for each read beat. The response monitor compares each
// strobed beat against the oldest queued response, field by field.
module tb_top;
	import msd_pkg::*;

	localparam int SERIES_MAX    = 1024;
	localparam int PERIOD_MAX    = 256;
	localparam int STALL_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic start;
	req_t req;
	logic busy;
	logic result_valid;
	rsp_t result;

	moving_average_seasonal_decomposer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.req(req),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------- shadow model state ----------------
	logic [WIN_REG_W-1:0] win_reg;
	logic [PER_REG_W-1:0] per_reg;
	longint series_val [SERIES_MAX];
	longint run_sum [SERIES_MAX+1];
	longint phase_acc [PERIOD_MAX];
	longint phase_cnt [PERIOD_MAX];
	longint phase_avg [PERIOD_MAX];
	longint season_offset;
	int series_len;
	bit series_clipped;
	bit decomp_ready;
	int active_period;

	rsp_t pending_rsp[$];
	int errors;
	int stall_cycles;
	int sender_idle_pct;  // chance, in percent, of a gap before a beat

	function automatic longint window_len();
		longint w;
		w = (win_reg == 0) ? 1 : win_reg;
		if (w > 255) w = 255;
		if (w % 2 == 0) w++;
		return w;
	endfunction

	// Centered moving average in Q8; clipped at the edges but always scaled by
	// the full window.
	function automatic longint trend_q8(int i);
		longint w, half, lo, hi;
		w = window_len();
		half = w / 2;
		lo = i - half;
		hi = i + half + 1;
		if (lo < 0) lo = 0;
		if (hi > series_len) hi = series_len;
		return ((run_sum[hi] - run_sum[lo]) * 256) / w;
	endfunction

	function automatic void run_decomposition();
		longint total;
		active_period = (per_reg > PERIOD_MAX) ? PERIOD_MAX : per_reg;
		for (int k = 0; k < PERIOD_MAX; k++) begin
			phase_acc[k] = 0;
			phase_cnt[k] = 0;
		end
		season_offset = 0;
		if (active_period != 0) begin
			total = 0;
			for (int i = 0; i < series_len; i++) begin
				phase_acc[i % active_period] += series_val[i] * 256 - trend_q8(i);
				phase_cnt[i % active_period] += 1;
			end
			for (int k = 0; k < active_period; k++)
				phase_avg[k] = (phase_cnt[k] > 0) ? phase_acc[k] / phase_cnt[k] : 0;
			for (int i = 0; i < series_len; i++)
				total += phase_avg[i % active_period];
			season_offset = (series_len > 0) ? total / series_len : 0;
		end
		decomp_ready = 1'b1;
	endfunction

	// Called for every accepted beat; read beats queue a response.
	function automatic void absorb_beat(req_t it);
		rsp_t r;
		longint y, tr, se, re;
		if (it.req_type == REQ_APPEND) begin
			if (decomp_ready) begin
				series_len = 0;
				series_clipped = 1'b0;
				decomp_ready = 1'b0;
			end
			if (series_len < SERIES_MAX) begin
				series_val[series_len] = $signed(it.sample);
				run_sum[series_len+1] = run_sum[series_len] + $signed(it.sample);
				series_len++;
			end else begin
				series_clipped = 1'b1;
			end
			if (it.last) run_decomposition();
		end else begin
			tr = 0;
			se = 0;
			re = 0;
			r.status = STAT_BAD;
			if (decomp_ready && it.index < series_len) begin
				y = series_val[it.index] * 256;
				tr = trend_q8(it.index);
				if (active_period != 0)
					se = phase_avg[it.index % active_period] - season_offset;
				re = y - tr - se;
				r.status = series_clipped ? STAT_TRUNC : STAT_OK;
			end
			r.trend_value = tr[TREND_W-1:0];
			r.season_value = se[SEASON_W-1:0];
			r.residual_value = re[RESID_W-1:0];
			r.read_index = it.index;
			pending_rsp.push_back(r);
		end
	endfunction

	// ---------------- monitor and watchdog ----------------
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n) begin
			if (result_valid) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, result);
					errors++;
				end else begin
					exp_r = pending_rsp.pop_front();
					if (result.trend_value !== exp_r.trend_value) begin
						$display("%0t: trend_value exp %0d got %0d", $time,
							exp_r.trend_value, result.trend_value);
						errors++;
					end
					if (result.season_value !== exp_r.season_value) begin
						$display("%0t: season_value exp %0d got %0d", $time,
							exp_r.season_value, result.season_value);
						errors++;
					end
					if (result.residual_value !== exp_r.residual_value) begin
						$display("%0t: residual_value exp %0d got %0d", $time,
							exp_r.residual_value, result.residual_value);
						errors++;
					end
					if (result.read_index !== exp_r.read_index) begin
						$display("%0t: read_index exp %0d got %0d", $time,
							exp_r.read_index, result.read_index);
						errors++;
					end
					if (result.status !== exp_r.status) begin
						$display("%0t: status exp %0d got %0d", $time,
							exp_r.status, result.status);
						errors++;
					end
				end
			end
			if (start && !busy) absorb_beat(req);
			// Long computations hold busy with nothing accepted, so the limit
			// covers a full-length series with the largest period.
			if ((start && !busy) || result_valid)
				stall_cycles = 0;
			else if (++stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// ---------------- driving helpers ----------------
	// Entered and left at a falling edge. start stays high across
	// back-to-back beats unless a gap is drawn.
	task automatic send_beat(req_t it);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start <= 1'b1;
		req <= it;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic append(logic signed [SAMPLE_BITS-1:0] s, logic fin);
		req_t it;
		it.req_type = REQ_APPEND;
		it.sample = s;
		it.last = fin;
		it.index = INDEX_W'($urandom());
		send_beat(it);
	endtask

	task automatic read_at(logic [INDEX_W-1:0] idx);
		req_t it;
		it.req_type = REQ_READ;
		it.sample = SAMPLE_BITS'($urandom());
		it.last = 1'($urandom());
		it.index = idx;
		send_beat(it);
	endtask

	// Drop start, then wait until every response is in and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending_rsp.size() != 0 || busy) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Only called from an idle block, after drain().
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_TREND_WINDOW) win_reg = val[WIN_REG_W-1:0];
		else per_reg = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_series(int len);
		for (int i = 0; i < len; i++)
			append(SAMPLE_BITS'($urandom()), i == len - 1);
	endtask

	// ---------------- tests ----------------
	// Nothing computed yet: every read reports a bad index.
	task automatic test_read_before_compute();
		read_at(0);
		read_at(10'h3FF);
		read_at(10'h155);
		drain();
	endtask

	// Sample extremes, default window, no season.
	task automatic test_extremes_no_season();
		write_reg(REG_TREND_WINDOW, 1);
		write_reg(REG_SEASON_PERIOD, 0);
		append(16'sh7FFF, 1'b0);
		append(-16'sd32768, 1'b0);
		append(16'sd0, 1'b0);
		append(-16'sd1, 1'b0);
		append(16'sd1, 1'b1);
		for (int i = 0; i < 6; i++) read_at(INDEX_W'(i));
		read_at(10'h3FF);
		drain();
	endtask

	// Even and zero windows, window changed between compute and reads,
	// then an append after results starts a fresh series.
	task automatic test_window_edges();
		write_reg(REG_TREND_WINDOW, 254);
		write_reg(REG_SEASON_PERIOD, 3);
		append(16'sh7FFF, 1'b0);
		append(16'sh7FFF, 1'b0);
		append(-16'sd32768, 1'b0);
		append(16'sd100, 1'b0);
		append(-16'sd7, 1'b0);
		append(16'sd3, 1'b0);
		append(-16'sd32768, 1'b1);
		read_at(0);
		read_at(6);
		drain();
		write_reg(REG_TREND_WINDOW, 0);
		read_at(3);
		read_at(7);
		drain();
		write_reg(REG_TREND_WINDOW, 2);
		read_at(2);
		append(16'sd5, 1'b0);
		read_at(0);  // series reopened, not ready
		append(-16'sd5, 1'b1);
		read_at(0);
		read_at(1);
		drain();
	endtask

	// Overfill the store; the period is clamped to its maximum.
	task automatic test_truncation();
		write_reg(REG_TREND_WINDOW, 255);
		write_reg(REG_SEASON_PERIOD, 511);
		load_series(SERIES_MAX + 6);
		read_at(0);
		read_at(10'h3FF);
		read_at(10'h200);
		drain();
		write_reg(REG_SEASON_PERIOD, 256);
		load_series(300);
		read_at(299);
		read_at(300);
		drain();
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_window();
		case ($urandom_range(9))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'(254);
			3: return CFG_DATA_W'(255);
			4: return CFG_DATA_W'($urandom_range(255));
			default: return CFG_DATA_W'($urandom_range(1, 15));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_period(int len);
		case ($urandom_range(11))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'(256);
			3: return CFG_DATA_W'($urandom_range(257, 511));
			4: return CFG_DATA_W'($urandom_range(255));
			default: return CFG_DATA_W'($urandom_range(1, (len < 2) ? 2 : len));
		endcase
	endfunction

	// Well-formed series with random content and reads, plus stray reads
	// during loading and reads past the end.
	task automatic test_random_series(int beats, int idle_pct);
		int sent, len, nrd, sel;
		logic signed [SAMPLE_BITS-1:0] s;
		sender_idle_pct = idle_pct;
		sent = 0;
		while (sent < beats) begin
			drain();
			sel = $urandom_range(99);
			if (sel < 90) len = $urandom_range(1, 48);
			else if (sel < 98) len = $urandom_range(49, 300);
			else len = $urandom_range(301, SERIES_MAX);
			write_reg(REG_TREND_WINDOW, pick_window());
			write_reg(REG_SEASON_PERIOD, pick_period(len));
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(19))
					0: s = 16'sh7FFF;
					1: s = -16'sd32768;
					default: s = SAMPLE_BITS'($urandom());
				endcase
				if ($urandom_range(99) < 4) begin
					read_at(INDEX_W'($urandom()));
					sent++;
				end
				append(s, i == len - 1);
				sent++;
			end
			nrd = $urandom_range(3, 20);
			for (int k = 0; k < nrd; k++) begin
				if (k == nrd / 2 && $urandom_range(9) == 0) begin
					drain();
					write_reg(REG_TREND_WINDOW, pick_window());
				end
				if ($urandom_range(99) < 15) read_at(INDEX_W'($urandom()));
				else read_at(INDEX_W'($urandom_range(len - 1)));
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		errors = 0;
		stall_cycles = 0;
		sender_idle_pct = 8;
		win_reg = 1;
		per_reg = 0;
		series_len = 0;
		series_clipped = 1'b0;
		decomp_ready = 1'b0;
		active_period = 0;
		season_offset = 0;
		run_sum[0] = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		start = 1'b0;
		req = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_read_before_compute();
		test_extremes_no_season();
		test_window_edges();
		test_truncation();
		test_random_series(150, 8);
		test_random_series(150, 61);
		test_random_series(150, 0);

		drain();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/msd_pkg.sv
sv/msd_ram.sv
sv/msd_div.sv
sv/msd_datapath.sv
sv/msd_ctrl.sv
sv/moving_average_seasonal_decomposer.sv
bench/tb_top.sv
